FILE: rtl/mer_pkg.sv
// ----------------------------------------------------------------------------
// mer_pkg
// Shared widths, codes and controller/datapath types for the midpoint
// ellipse rasteriser.
// ----------------------------------------------------------------------------
`default_nettype none

package mer_pkg;

    localparam int COORD_W   = 16;
    localparam int RAD_W     = 11;
    localparam int OFS_W     = 12;
    localparam int SQ_W      = 22;
    localparam int ACC_W     = 48;
    localparam int MUL_W     = 25;
    localparam int CFG_IDX_W = 3;
    localparam int MIRRORS   = 4;
    localparam int PAT_SEL_W = 4;

    localparam logic [RAD_W-1:0] MAX_RADIUS = 11'd2047;

    // request codes
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_STEP  = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_MIN_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_MAX_X  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_MIN_Y  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_MAX_Y  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_PATTERN = 3'd4;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_START,
        OP_SKIP,
        OP_MUL_RX2,
        OP_MUL_RY2,
        OP_MUL_RXRY,
        OP_INIT_DEC,
        OP_EN_XX,
        OP_EN_A,
        OP_EN_YY,
        OP_EN_B,
        OP_EN_C,
        OP_EN_D,
        OP_STEP_A,
        OP_STEP_B,
        OP_FIN,
        OP_MASK,
        OP_EMIT
    } op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RX2,
        ST_RY2,
        ST_RXRY,
        ST_INIT,
        ST_CHK,
        ST_EN_XX,
        ST_EN_A,
        ST_EN_YY,
        ST_EN_B,
        ST_EN_C,
        ST_EN_D,
        ST_STEP_A,
        ST_STEP_B,
        ST_FIN,
        ST_MASK,
        ST_EMIT
    } state_t;

    typedef struct packed {
        op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic y_zero;
        logic step_ge;
        logic region_two;
        logic finished;
        logic emit_last;
    } dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/mer_ctrl.sv
// ----------------------------------------------------------------------------
// mer_ctrl
// Sequencer for the ellipse rasteriser: walks the datapath through setup,
// region changeover, one iteration and result emission.
// ----------------------------------------------------------------------------
`default_nettype none

module mer_ctrl
    import mer_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic       s_req_type,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_req_type == REQ_START) begin
                        cmd.op     = OP_START;
                        state_next = ST_RX2;
                    end else if (status.finished) begin
                        cmd.op     = OP_SKIP;
                        state_next = ST_MASK;
                    end else begin
                        state_next = ST_STEP_A;
                    end
                end
            end
            ST_RX2: begin
                cmd.op     = OP_MUL_RX2;
                state_next = ST_RY2;
            end
            ST_RY2: begin
                cmd.op     = OP_MUL_RY2;
                state_next = ST_RXRY;
            end
            ST_RXRY: begin
                cmd.op     = OP_MUL_RXRY;
                state_next = ST_INIT;
            end
            ST_INIT: begin
                cmd.op     = OP_INIT_DEC;
                state_next = ST_CHK;
            end
            ST_CHK: begin
                // zero x radius goes straight to region two unless the y radius is zero too
                if (!status.y_zero && status.step_ge) begin
                    state_next = ST_EN_XX;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_EN_XX: begin
                cmd.op     = OP_EN_XX;
                state_next = ST_EN_A;
            end
            ST_EN_A: begin
                cmd.op     = OP_EN_A;
                state_next = ST_EN_YY;
            end
            ST_EN_YY: begin
                cmd.op     = OP_EN_YY;
                state_next = ST_EN_B;
            end
            ST_EN_B: begin
                cmd.op     = OP_EN_B;
                state_next = ST_EN_C;
            end
            ST_EN_C: begin
                cmd.op     = OP_EN_C;
                state_next = ST_EN_D;
            end
            ST_EN_D: begin
                cmd.op     = OP_EN_D;
                state_next = ST_FIN;
            end
            ST_STEP_A: begin
                cmd.op     = OP_STEP_A;
                state_next = ST_STEP_B;
            end
            ST_STEP_B: begin
                cmd.op = OP_STEP_B;
                if (!status.region_two && status.step_ge) begin
                    state_next = ST_EN_XX;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                cmd.op     = OP_FIN;
                state_next = ST_MASK;
            end
            ST_MASK: begin
                cmd.op     = OP_MASK;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                cmd.op = OP_EMIT;
                if (status.emit_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/mer_datapath.sv
// ----------------------------------------------------------------------------
// mer_datapath
// Ellipse state, shared multiplier, iteration adders, clip and pattern test
// and the result output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mer_datapath
    import mer_pkg::*;
(
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire dp_cmd_t                     cmd,
    output dp_status_t                       status,
    input  wire logic                        cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [COORD_W-1:0]          cfg_wr_data,
    input  wire logic signed [COORD_W-1:0]   s_center_x,
    input  wire logic signed [COORD_W-1:0]   s_center_y,
    input  wire logic [RAD_W-1:0]            s_radius_x,
    input  wire logic [RAD_W-1:0]            s_radius_y,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic signed [COORD_W-1:0]        m_pixel_x,
    output logic signed [COORD_W-1:0]        m_pixel_y,
    output logic                             m_pixel_valid,
    output logic                             m_last,
    output logic                             m_done_res
);

    // configuration
    logic signed [COORD_W-1:0] clip_min_x_reg, clip_min_x_next;
    logic signed [COORD_W-1:0] clip_max_x_reg, clip_max_x_next;
    logic signed [COORD_W-1:0] clip_min_y_reg, clip_min_y_next;
    logic signed [COORD_W-1:0] clip_max_y_reg, clip_max_y_next;
    logic [COORD_W-1:0]        pattern_reg, pattern_next;

    // ellipse state
    logic signed [COORD_W-1:0] cx_reg, cx_next;
    logic signed [COORD_W-1:0] cy_reg, cy_next;
    logic [RAD_W-1:0]          rx_reg, rx_next;
    logic [RAD_W-1:0]          ry_reg, ry_next;
    logic [SQ_W-1:0]           rx2_reg, rx2_next;
    logic [SQ_W-1:0]           ry2_reg, ry2_next;
    logic [OFS_W-1:0]          x_reg, x_next;
    logic [OFS_W-1:0]          y_reg, y_next;
    logic signed [ACC_W-1:0]   dec_reg, dec_next;
    logic signed [ACC_W-1:0]   spx_reg, spx_next;
    logic signed [ACC_W-1:0]   spy_reg, spy_next;
    logic signed [ACC_W-1:0]   prod_reg, prod_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic                      region_reg, region_next;
    logic                      finished_reg, finished_next;
    logic                      flag_reg, flag_next;
    logic                      draw_reg, draw_next;
    logic [MIRRORS-1:0]        mask_reg, mask_next;
    logic                      nil_reg, nil_next;

    // output register
    logic                      m_valid_reg, m_valid_next;
    logic signed [COORD_W-1:0] m_pixel_x_reg, m_pixel_x_next;
    logic signed [COORD_W-1:0] m_pixel_y_reg, m_pixel_y_next;
    logic                      m_pixel_valid_reg, m_pixel_valid_next;
    logic                      m_last_reg, m_last_next;
    logic                      m_done_res_reg, m_done_res_next;

    // shared multiplier
    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [2*MUL_W-1:0] mul_p;
    logic signed [OFS_W:0]     ym1;

    // clip and emission
    logic signed [COORD_W:0]   px_p, px_m, py_p, py_m;
    logic signed [COORD_W:0]   min_x, max_x, min_y, max_y;
    logic                      xp_ok, xm_ok, yp_ok, ym_ok;
    logic [MIRRORS-1:0]        vis;
    logic [MIRRORS-1:0]        sel, rem;
    logic signed [COORD_W:0]   sel_x, sel_y;
    logic                      slot_free;
    logic [RAD_W-1:0]          rx_sat, ry_sat;
    logic signed [ACC_W-1:0]   ry2_ext, rx2_ext, ry2_x2, rx2_x2, rx2_q;

    assign ym1 = $signed({1'b0, y_reg}) - $signed({{OFS_W{1'b0}}, 1'b1});

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_MUL_RX2: begin
                mul_a = $signed({{(MUL_W-RAD_W){1'b0}}, rx_reg});
                mul_b = mul_a;
            end
            OP_MUL_RY2: begin
                mul_a = $signed({{(MUL_W-RAD_W){1'b0}}, ry_reg});
                mul_b = mul_a;
            end
            OP_MUL_RXRY: begin
                mul_a = $signed({{(MUL_W-SQ_W){1'b0}}, rx2_reg});
                mul_b = $signed({{(MUL_W-RAD_W){1'b0}}, ry_reg});
            end
            OP_EN_XX: begin
                mul_a = $signed({{(MUL_W-OFS_W){1'b0}}, x_reg});
                mul_b = mul_a;
            end
            OP_EN_A: begin
                mul_a = $signed({{(MUL_W-SQ_W){1'b0}}, ry2_reg});
                mul_b = prod_reg[MUL_W-1:0];
            end
            OP_EN_YY: begin
                mul_a = $signed({{(MUL_W-OFS_W-1){ym1[OFS_W]}}, ym1});
                mul_b = mul_a;
            end
            OP_EN_B: begin
                mul_a = $signed({{(MUL_W-SQ_W){1'b0}}, rx2_reg});
                mul_b = prod_reg[MUL_W-1:0];
            end
            OP_EN_C: begin
                mul_a = $signed({{(MUL_W-SQ_W){1'b0}}, rx2_reg});
                mul_b = $signed({{(MUL_W-SQ_W){1'b0}}, ry2_reg});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign ry2_ext = $signed({{(ACC_W-SQ_W){1'b0}}, ry2_reg});
    assign rx2_ext = $signed({{(ACC_W-SQ_W){1'b0}}, rx2_reg});
    assign ry2_x2  = $signed({{(ACC_W-SQ_W-1){1'b0}}, ry2_reg, 1'b0});
    assign rx2_x2  = $signed({{(ACC_W-SQ_W-1){1'b0}}, rx2_reg, 1'b0});
    assign rx2_q   = $signed({{(ACC_W-SQ_W+2){1'b0}}, rx2_reg[SQ_W-1:2]});

    assign rx_sat = (s_radius_x > MAX_RADIUS) ? MAX_RADIUS : s_radius_x;
    assign ry_sat = (s_radius_y > MAX_RADIUS) ? MAX_RADIUS : s_radius_y;

    // four mirrored candidates at full precision
    always_comb begin
        px_p  = $signed({cx_reg[COORD_W-1], cx_reg})
              + $signed({{(COORD_W+1-OFS_W){1'b0}}, x_reg});
        px_m  = $signed({cx_reg[COORD_W-1], cx_reg})
              - $signed({{(COORD_W+1-OFS_W){1'b0}}, x_reg});
        py_p  = $signed({cy_reg[COORD_W-1], cy_reg})
              + $signed({{(COORD_W+1-OFS_W){1'b0}}, y_reg});
        py_m  = $signed({cy_reg[COORD_W-1], cy_reg})
              - $signed({{(COORD_W+1-OFS_W){1'b0}}, y_reg});
        min_x = $signed({clip_min_x_reg[COORD_W-1], clip_min_x_reg});
        max_x = $signed({clip_max_x_reg[COORD_W-1], clip_max_x_reg});
        min_y = $signed({clip_min_y_reg[COORD_W-1], clip_min_y_reg});
        max_y = $signed({clip_max_y_reg[COORD_W-1], clip_max_y_reg});
        xp_ok = (px_p > min_x) && (px_p < max_x);
        xm_ok = (px_m > min_x) && (px_m < max_x);
        yp_ok = (py_p > min_y) && (py_p < max_y);
        ym_ok = (py_m > min_y) && (py_m < max_y);
        vis   = {xm_ok & ym_ok, xp_ok & ym_ok, xm_ok & yp_ok, xp_ok & yp_ok};
        sel   = mask_reg & (~mask_reg + 1'b1);
        rem   = mask_reg & ~sel;
        sel_x = (sel[0] || sel[2]) ? px_p : px_m;
        sel_y = (sel[0] || sel[1]) ? py_p : py_m;
    end

    assign slot_free = !m_valid_reg || m_ready;

    always_comb begin
        clip_min_x_next    = clip_min_x_reg;
        clip_max_x_next    = clip_max_x_reg;
        clip_min_y_next    = clip_min_y_reg;
        clip_max_y_next    = clip_max_y_reg;
        pattern_next       = pattern_reg;
        cx_next            = cx_reg;
        cy_next            = cy_reg;
        rx_next            = rx_reg;
        ry_next            = ry_reg;
        rx2_next           = rx2_reg;
        ry2_next           = ry2_reg;
        x_next             = x_reg;
        y_next             = y_reg;
        dec_next           = dec_reg;
        spx_next           = spx_reg;
        spy_next           = spy_reg;
        prod_next          = prod_reg;
        acc_next           = acc_reg;
        region_next        = region_reg;
        finished_next      = finished_reg;
        flag_next          = flag_reg;
        draw_next          = draw_reg;
        mask_next          = mask_reg;
        nil_next           = nil_reg;
        m_valid_next       = m_valid_reg;
        m_pixel_x_next     = m_pixel_x_reg;
        m_pixel_y_next     = m_pixel_y_reg;
        m_pixel_valid_next = m_pixel_valid_reg;
        m_last_next        = m_last_reg;
        m_done_res_next    = m_done_res_reg;

        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_CLIP_MIN_X:   clip_min_x_next = $signed(cfg_wr_data);
                CFG_CLIP_MAX_X:   clip_max_x_next = $signed(cfg_wr_data);
                CFG_CLIP_MIN_Y:   clip_min_y_next = $signed(cfg_wr_data);
                CFG_CLIP_MAX_Y:   clip_max_y_next = $signed(cfg_wr_data);
                CFG_LINE_PATTERN: pattern_next    = cfg_wr_data;
                default: begin
                end
            endcase
        end

        if (slot_free) begin
            m_valid_next = 1'b0;
        end

        case (cmd.op) inside
            OP_START: begin
                cx_next     = s_center_x;
                cy_next     = s_center_y;
                rx_next     = rx_sat;
                ry_next     = ry_sat;
                x_next      = '0;
                y_next      = {1'b0, ry_sat};
                spx_next    = '0;
                region_next = 1'b0;
                draw_next   = 1'b1;
            end
            OP_SKIP: begin
                draw_next = 1'b0;
            end
            OP_MUL_RX2: begin
                prod_next = mul_p[ACC_W-1:0];
            end
            OP_MUL_RY2: begin
                rx2_next  = prod_reg[SQ_W-1:0];
                prod_next = mul_p[ACC_W-1:0];
            end
            OP_MUL_RXRY: begin
                ry2_next  = prod_reg[SQ_W-1:0];
                prod_next = mul_p[ACC_W-1:0];
            end
            OP_INIT_DEC: begin
                spy_next = {prod_reg[ACC_W-2:0], 1'b0};
                dec_next = ry2_ext - prod_reg + rx2_q;
            end
            OP_EN_XX, OP_EN_A, OP_EN_B: begin
                prod_next = mul_p[ACC_W-1:0];
            end
            OP_EN_YY: begin
                acc_next  = prod_reg;
                prod_next = mul_p[ACC_W-1:0];
            end
            OP_EN_C: begin
                acc_next  = acc_reg + prod_reg;
                prod_next = mul_p[ACC_W-1:0];
            end
            OP_EN_D: begin
                dec_next    = acc_reg - prod_reg;
                region_next = 1'b1;
            end
            OP_STEP_A: begin
                if (!region_reg) begin
                    flag_next = !dec_reg[ACC_W-1];
                    x_next    = x_reg + 1'b1;
                    spx_next  = spx_reg + ry2_x2;
                    if (!dec_reg[ACC_W-1]) begin
                        y_next   = y_reg - 1'b1;
                        spy_next = spy_reg - rx2_x2;
                    end
                end else begin
                    // flag holds "decision not positive"
                    flag_next = dec_reg[ACC_W-1] || (dec_reg == '0);
                    y_next    = y_reg - 1'b1;
                    spy_next  = spy_reg - rx2_x2;
                    if (dec_reg[ACC_W-1] || (dec_reg == '0)) begin
                        x_next   = x_reg + 1'b1;
                        spx_next = spx_reg + ry2_x2;
                    end
                end
            end
            OP_STEP_B: begin
                if (!region_reg) begin
                    dec_next  = dec_reg + ry2_ext + spx_reg - (flag_reg ? spy_reg : '0);
                    draw_next = pattern_reg[x_reg[PAT_SEL_W-1:0]];
                end else begin
                    dec_next  = dec_reg + rx2_ext - spy_reg + (flag_reg ? spx_reg : '0);
                    draw_next = pattern_reg[y_reg[PAT_SEL_W-1:0]];
                end
            end
            OP_FIN: begin
                finished_next = (y_reg == '0);
            end
            OP_MASK: begin
                mask_next = draw_reg ? vis : '0;
                nil_next  = !draw_reg || (vis == '0);
            end
            OP_EMIT: begin
                if (slot_free) begin
                    m_valid_next    = 1'b1;
                    m_done_res_next = finished_reg;
                    if (nil_reg) begin
                        m_pixel_x_next     = '0;
                        m_pixel_y_next     = '0;
                        m_pixel_valid_next = 1'b0;
                        m_last_next        = 1'b1;
                    end else begin
                        m_pixel_x_next     = sel_x[COORD_W-1:0];
                        m_pixel_y_next     = sel_y[COORD_W-1:0];
                        m_pixel_valid_next = 1'b1;
                        m_last_next        = (rem == '0);
                        mask_next          = rem;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clip_min_x_reg <= '0;
            clip_max_x_reg <= 16'sd32767;
            clip_min_y_reg <= '0;
            clip_max_y_reg <= 16'sd32767;
            pattern_reg    <= 16'hFFFF;
            region_reg     <= 1'b0;
            finished_reg   <= 1'b1;
            x_reg          <= '0;
            y_reg          <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            clip_min_x_reg <= clip_min_x_next;
            clip_max_x_reg <= clip_max_x_next;
            clip_min_y_reg <= clip_min_y_next;
            clip_max_y_reg <= clip_max_y_next;
            pattern_reg    <= pattern_next;
            region_reg     <= region_next;
            finished_reg   <= finished_next;
            x_reg          <= x_next;
            y_reg          <= y_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cx_reg            <= cx_next;
        cy_reg            <= cy_next;
        rx_reg            <= rx_next;
        ry_reg            <= ry_next;
        rx2_reg           <= rx2_next;
        ry2_reg           <= ry2_next;
        dec_reg           <= dec_next;
        spx_reg           <= spx_next;
        spy_reg           <= spy_next;
        prod_reg          <= prod_next;
        acc_reg           <= acc_next;
        flag_reg          <= flag_next;
        draw_reg          <= draw_next;
        mask_reg          <= mask_next;
        nil_reg           <= nil_next;
        m_pixel_x_reg     <= m_pixel_x_next;
        m_pixel_y_reg     <= m_pixel_y_next;
        m_pixel_valid_reg <= m_pixel_valid_next;
        m_last_reg        <= m_last_next;
        m_done_res_reg    <= m_done_res_next;
    end

    always_comb begin
        status.y_zero     = (y_reg == '0);
        status.step_ge    = !(spx_reg < spy_reg);
        status.region_two = region_reg;
        status.finished   = finished_reg;
        status.emit_last  = (cmd.op == OP_EMIT) && slot_free && (nil_reg || (rem == '0));
    end

    assign m_valid       = m_valid_reg;
    assign m_pixel_x     = m_pixel_x_reg;
    assign m_pixel_y     = m_pixel_y_reg;
    assign m_pixel_valid = m_pixel_valid_reg;
    assign m_last        = m_last_reg;
    assign m_done_res    = m_done_res_reg;

`ifndef SYNTHESIS
    a_blank_result_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_pixel_valid_reg) |-> (m_pixel_x_reg == '0 && m_pixel_y_reg == '0))
        else $error("blank result carries non-zero coordinates");

    a_region_two_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (region_reg && cmd.op != OP_START) |=> region_reg)
        else $error("left region two without a new start");

    a_y_never_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op != OP_START) |=> (y_reg <= $past(y_reg)))
        else $error("y offset increased during an outline");

    a_emit_drops_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_EMIT && slot_free && !nil_reg)
        |=> ($countones(mask_reg) + 1 == $countones($past(mask_reg))))
        else $error("pixel transfer did not retire exactly one mirror");
`endif

endmodule

`default_nettype wire

FILE: rtl/midpoint_ellipse_rasterizer.sv
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer
// Integer midpoint ellipse outline generator with clipping and dash pattern.
// ----------------------------------------------------------------------------
// A start request latches centre and radii and produces the clipped mirrored
// copies of (0, radius_y); each step request runs one midpoint iteration and
// produces up to four clipped pixels, or a single blank result, with last on
// the final transfer and done_res once y has reached zero. Items are handled
// one at a time: a request is not taken until every result of the last one
// has been placed in the result register. The iteration that crosses into
// region two also forms the new decision value on the single shared 25x25
// multiplier. A step after the outline is done returns its blank result. The
// result register lets the next request be taken while a result waits. Clip
// and pattern registers must be written through cfg_wr_en/cfg_index/
// cfg_wr_data with the block idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module midpoint_ellipse_rasterizer
    import mer_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [COORD_W-1:0]        cfg_wr_data,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic                      s_req_type,
    input  wire logic signed [COORD_W-1:0] s_center_x,
    input  wire logic signed [COORD_W-1:0] s_center_y,
    input  wire logic [RAD_W-1:0]          s_radius_x,
    input  wire logic [RAD_W-1:0]          s_radius_y,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic signed [COORD_W-1:0]      m_pixel_x,
    output logic signed [COORD_W-1:0]      m_pixel_y,
    output logic                           m_pixel_valid,
    output logic                           m_last,
    output logic                           m_done_res
);

    dp_cmd_t    cmd;
    dp_status_t status;

    mer_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .status     (status),
        .cmd        (cmd)
    );

    mer_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_center_x    (s_center_x),
        .s_center_y    (s_center_y),
        .s_radius_x    (s_radius_x),
        .s_radius_y    (s_radius_y),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_x     (m_pixel_x),
        .m_pixel_y     (m_pixel_y),
        .m_pixel_valid (m_pixel_valid),
        .m_last        (m_last),
        .m_done_res    (m_done_res)
    );

endmodule

`default_nettype wire

FILE: tb/sv/midpoint_ellipse_rasterizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer_tb
// Self-checking bench for the midpoint ellipse outline generator. A directed
// table covers the axis cases, extreme centres and radii and steps past the
// end of an outline; random start/step sequences follow under several clip
// windows and dash patterns. Every pixel transfer is checked against a local
// model of the midpoint iteration, with bursty input and a stalling output.
// ----------------------------------------------------------------------------

module midpoint_ellipse_rasterizer_tb;

    import mer_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int IDLE_GAP    = 24;
    localparam int DIR_ROWS    = 25;
    localparam int HOLD_AFTER  = 120;
    localparam int HOLD_CYCLES = 400;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic                      visible;
        logic                      last;
        logic                      done;
    } pixel_res_t;

    typedef struct {
        logic       req;
        int         cx;
        int         cy;
        int         rx;
        int         ry;
        bit         typed;
        pixel_res_t want;
    } dir_row_t;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_HALF,
        RX_SPARSE,
        RX_TOGGLE
    } rx_mode_t;

    // blank transfers whose value is obvious from the algorithm
    localparam pixel_res_t BLANK_DONE = '{16'sd0, 16'sd0, 1'b0, 1'b1, 1'b1};
    localparam pixel_res_t BLANK_LIVE = '{16'sd0, 16'sd0, 1'b0, 1'b1, 1'b0};

    logic                      aclk;
    logic                      aresetn;
    logic                      cfg_wr_en;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [COORD_W-1:0]        cfg_wr_data;
    logic                      s_valid;
    logic                      s_ready;
    logic                      s_req_type;
    logic signed [COORD_W-1:0] s_center_x;
    logic signed [COORD_W-1:0] s_center_y;
    logic [RAD_W-1:0]          s_radius_x;
    logic [RAD_W-1:0]          s_radius_y;
    logic                      m_valid;
    logic                      m_ready;
    logic signed [COORD_W-1:0] m_pixel_x;
    logic signed [COORD_W-1:0] m_pixel_y;
    logic                      m_pixel_valid;
    logic                      m_last;
    logic                      m_done_res;

    midpoint_ellipse_rasterizer i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_center_x    (s_center_x),
        .s_center_y    (s_center_y),
        .s_radius_x    (s_radius_x),
        .s_radius_y    (s_radius_y),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_x     (m_pixel_x),
        .m_pixel_y     (m_pixel_y),
        .m_pixel_valid (m_pixel_valid),
        .m_last        (m_last),
        .m_done_res    (m_done_res)
    );

    // outline model state
    longint           clip_min_x, clip_max_x, clip_min_y, clip_max_y;
    logic [15:0]      line_pattern;
    bit               rgn_two;
    longint           ofs_x, ofs_y;
    longint           decision, step_px, step_py;
    longint           rx_sq, ry_sq;
    longint           centre_x, centre_y;
    bit               outline_done;

    pixel_res_t       item_pixels[$];
    pixel_res_t       expected_pixels[$];
    dir_row_t         dir_rows[DIR_ROWS];

    int               mismatch_count;
    int               cycle_count;
    int               items_sent;
    int               burst_left;
    int               hold_left;
    bit               hold_done;
    int               mode_left;
    rx_mode_t         rx_mode;

    // ------------------------------------------------------------------------
    // model of the midpoint iteration
    // ------------------------------------------------------------------------
    function automatic void reset_outline();
        clip_min_x   = 0;
        clip_max_x   = 32767;
        clip_min_y   = 0;
        clip_max_y   = 32767;
        line_pattern = 16'hFFFF;
        rgn_two      = 1'b0;
        ofs_x        = 0;
        ofs_y        = 0;
        decision     = 0;
        step_px      = 0;
        step_py      = 0;
        rx_sq        = 0;
        ry_sq        = 0;
        centre_x     = 0;
        centre_y     = 0;
        outline_done = 1'b1;
    endfunction

    function automatic void clip_pixel(input longint x, input longint y);
        pixel_res_t r;
        if (x > clip_min_x && x < clip_max_x && y > clip_min_y && y < clip_max_y) begin
            r.px      = 16'(x);
            r.py      = 16'(y);
            r.visible = 1'b1;
            r.last    = 1'b0;
            r.done    = 1'b0;
            item_pixels.push_back(r);
        end
    endfunction

    function automatic void mirror_pixels(input bit draw);
        pixel_res_t r;
        if (draw) begin
            clip_pixel(centre_x + ofs_x, centre_y + ofs_y);
            clip_pixel(centre_x - ofs_x, centre_y + ofs_y);
            clip_pixel(centre_x + ofs_x, centre_y - ofs_y);
            clip_pixel(centre_x - ofs_x, centre_y - ofs_y);
        end
        if (item_pixels.size() == 0) begin
            r = '0;
            item_pixels.push_back(r);
        end
        foreach (item_pixels[k])
            item_pixels[k].done = outline_done;
        item_pixels[item_pixels.size()-1].last = 1'b1;
    endfunction

    // decision is reloaded from scratch when region two begins
    function automatic void enter_region_two();
        longint ym1;
        ym1      = ofs_y - 1;
        decision = ry_sq * ofs_x * ofs_x + rx_sq * ym1 * ym1 - rx_sq * ry_sq;
        rgn_two  = 1'b1;
    endfunction

    function automatic void predict_pixels(input logic req,
                                           input logic [COORD_W-1:0] cx,
                                           input logic [COORD_W-1:0] cy,
                                           input logic [RAD_W-1:0] rx,
                                           input logic [RAD_W-1:0] ry);
        longint rxl, ryl;
        bit     draw, take_step;
        item_pixels = {};
        if (req == REQ_START) begin
            rxl = longint'(rx);
            ryl = longint'(ry);
            if (rxl > longint'(MAX_RADIUS)) rxl = longint'(MAX_RADIUS);
            if (ryl > longint'(MAX_RADIUS)) ryl = longint'(MAX_RADIUS);
            centre_x     = longint'($signed(cx));
            centre_y     = longint'($signed(cy));
            rx_sq        = rxl * rxl;
            ry_sq        = ryl * ryl;
            ofs_x        = 0;
            ofs_y        = ryl;
            decision     = ry_sq - rx_sq * ryl + rx_sq / 4;
            step_px      = 0;
            step_py      = 2 * rx_sq * ryl;
            rgn_two      = 1'b0;
            outline_done = (ryl == 0);
            if (!outline_done && !(step_px < step_py))
                enter_region_two();
            mirror_pixels(1'b1);
        end else if (outline_done) begin
            mirror_pixels(1'b0);
        end else begin
            if (!rgn_two) begin
                take_step = (decision >= 0);
                ofs_x++;
                step_px += 2 * ry_sq;
                if (take_step) begin
                    ofs_y--;
                    step_py  -= 2 * rx_sq;
                    decision += ry_sq + step_px - step_py;
                end else begin
                    decision += ry_sq + step_px;
                end
                draw = line_pattern[4'(ofs_x)];
                if (!(step_px < step_py))
                    enter_region_two();
            end else begin
                take_step = !(decision > 0);
                ofs_y--;
                step_py -= 2 * rx_sq;
                if (take_step) begin
                    ofs_x++;
                    step_px  += 2 * ry_sq;
                    decision += rx_sq - step_py + step_px;
                end else begin
                    decision += rx_sq - step_py;
                end
                draw = line_pattern[4'(ofs_y)];
            end
            outline_done = (ofs_y <= 0);
            mirror_pixels(draw);
        end
    endfunction

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        case (idx)
            CFG_CLIP_MIN_X:   clip_min_x   = longint'($signed(data));
            CFG_CLIP_MAX_X:   clip_max_x   = longint'($signed(data));
            CFG_CLIP_MIN_Y:   clip_min_y   = longint'($signed(data));
            CFG_CLIP_MAX_Y:   clip_max_y   = longint'($signed(data));
            CFG_LINE_PATTERN: line_pattern = data;
            default: ;
        endcase
    endtask

    task automatic write_clip(input int min_x, input int max_x, input int min_y,
                              input int max_y, input logic [15:0] pattern);
        write_reg(CFG_CLIP_MIN_X, 16'(min_x));
        write_reg(CFG_CLIP_MAX_X, 16'(max_x));
        write_reg(CFG_CLIP_MIN_Y, 16'(min_y));
        write_reg(CFG_CLIP_MAX_Y, 16'(max_y));
        write_reg(CFG_LINE_PATTERN, pattern);
    endtask

    // offers one item, sender idles between bursts; typed rows replace the model's expected results
    task automatic send_item(input logic req, input logic [COORD_W-1:0] cx,
                             input logic [COORD_W-1:0] cy, input logic [RAD_W-1:0] rx,
                             input logic [RAD_W-1:0] ry, input bit typed,
                             input pixel_res_t want);
        int gap;
        @(negedge aclk);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 25) : $urandom_range(1, 4);
            repeat (gap) @(negedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 50)
                                                     : $urandom_range(1, 16);
        end
        s_valid    <= 1'b1;
        s_req_type <= req;
        s_center_x <= cx;
        s_center_y <= cy;
        s_radius_x <= rx;
        s_radius_y <= ry;
        burst_left--;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        predict_pixels(req, cx, cy, rx, ry);
        if (typed)
            expected_pixels.push_back(want);
        else
            foreach (item_pixels[k]) expected_pixels.push_back(item_pixels[k]);
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge aclk);
        repeat (IDLE_GAP) @(posedge aclk);
    endtask

    // mostly complete outlines with random content, some cut short, some stray steps
    task automatic run_outlines(input int n_items, input int span);
        int               sent, pick, n_steps, k;
        logic [COORD_W-1:0] cx, cy;
        logic [RAD_W-1:0]   rx, ry;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                send_item(REQ_STEP, 16'($urandom), 16'($urandom), 11'($urandom),
                          11'($urandom), 1'b0, '0);
                sent++;
            end else begin
                if ($urandom_range(0, 6) == 0) begin
                    cx = 16'($urandom);
                    cy = 16'($urandom);
                end else begin
                    cx = 16'(int'($urandom_range(0, 2 * span)) - span);
                    cy = 16'(int'($urandom_range(0, 2 * span)) - span);
                end
                case ($urandom_range(0, 9))
                    0: begin
                        rx = 11'($urandom);
                        ry = 11'($urandom);
                    end
                    1, 2: begin
                        rx = 11'($urandom_range(0, 150));
                        ry = 11'($urandom_range(0, 150));
                    end
                    default: begin
                        rx = 11'($urandom_range(0, 20));
                        ry = 11'($urandom_range(0, 20));
                    end
                endcase
                send_item(REQ_START, cx, cy, rx, ry, 1'b0, '0);
                sent++;
                if (pick < 18)
                    n_steps = $urandom_range(0, 3);
                else
                    n_steps = int'(rx) + int'(ry) + 1 + int'($urandom_range(0, 2));
                if (n_steps > 40) n_steps = 40;
                if (n_steps > n_items - sent) n_steps = n_items - sent;
                for (k = 0; k < n_steps; k++) begin
                    send_item(REQ_STEP, 16'($urandom), 16'($urandom), 11'($urandom),
                              11'($urandom), 1'b0, '0);
                    sent++;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // clock, receiver, checker, watchdog
    // ------------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // random ready modes, and one long hold-off once the run is going, so the block backs up
    initial begin
        m_ready   = 1'b0;
        hold_left = 0;
        hold_done = 1'b0;
        mode_left = 0;
        rx_mode   = RX_ALWAYS;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (!hold_done && items_sent >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                m_ready   <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    rx_mode   = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 80);
                end
                mode_left--;
                case (rx_mode)
                    RX_ALWAYS: m_ready <= 1'b1;
                    RX_HALF:   m_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                    default:   m_ready <= ~m_ready;
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        pixel_res_t got, want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_pixel_x, m_pixel_y, m_pixel_valid, m_last, m_done_res};
            if (expected_pixels.size() == 0) begin
                if (mismatch_count < MAX_REPORTS)
                    $display("unexpected transfer x=%0d y=%0d vis=%0b last=%0b done=%0b",
                             got.px, got.py, got.visible, got.last, got.done);
                mismatch_count++;
            end else begin
                want = expected_pixels.pop_front();
                if (got !== want) begin
                    if (mismatch_count < MAX_REPORTS)
                        $display({"mismatch: want x=%0d y=%0d vis=%0b last=%0b done=%0b,",
                                  " got x=%0d y=%0d vis=%0b last=%0b done=%0b"},
                                 want.px, want.py, want.visible, want.last, want.done,
                                 got.px, got.py, got.visible, got.last, got.done);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL midpoint_ellipse_rasterizer");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin
        int i;
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = '0;
        cfg_wr_data    = '0;
        s_valid        = 1'b0;
        s_req_type     = REQ_START;
        s_center_x     = '0;
        s_center_y     = '0;
        s_radius_x     = '0;
        s_radius_y     = '0;
        mismatch_count = 0;
        cycle_count    = 0;
        items_sent     = 0;
        burst_left     = 0;
        reset_outline();

        dir_rows = '{
            // step before any start
            '{REQ_STEP,  0,      0,      0,    0,    1'b1, BLANK_DONE},
            // flat ellipse on the clip corner: all clipped, done at once
            '{REQ_START, 0,      0,      5,    0,    1'b1, BLANK_DONE},
            '{REQ_STEP,  0,      0,      0,    0,    1'b1, BLANK_DONE},
            // zero horizontal radius goes straight to region two
            '{REQ_START, 100,    100,    0,    4,    1'b0, '0},
            '{REQ_STEP,  0,      0,      0,    0,    1'b0, '0},
            '{REQ_STEP,  0,      0,      0,    0,    1'b0, '0},
            '{REQ_STEP,  0,      0,      0,    0,    1'b0, '0},
            '{REQ_STEP,  0,      0,      0,    0,    1'b0, '0},
            '{REQ_STEP,  0,      0,      0,    0,    1'b0, '0},
            // extreme centres with the largest radii, first point clipped away
            '{REQ_START, 32767,  -32768, 2047, 2047, 1'b1, BLANK_LIVE},
            '{REQ_STEP,  0,      0,      0,    0,    1'b0, '0},
            '{REQ_START, -32768, 32767,  2047, 2047, 1'b1, BLANK_LIVE},
            '{REQ_START, 1000,   1000,   2047, 2047, 1'b0, '0},
            '{REQ_STEP,  0,      0,      0,    0,    1'b0, '0},
            '{REQ_STEP,  0,      0,      0,    0,    1'b0, '0},
            '{REQ_STEP,  0,      0,      0,    0,    1'b0, '0},
            // small outline run through the region change and past the end
            '{REQ_START, 50,     50,     5,    2,    1'b0, '0},
            '{REQ_STEP,  0,      0,      0,    0,    1'b0, '0},
            '{REQ_STEP,  0,      0,      0,    0,    1'b0, '0},
            '{REQ_STEP,  0,      0,      0,    0,    1'b0, '0},
            '{REQ_STEP,  0,      0,      0,    0,    1'b0, '0},
            '{REQ_STEP,  0,      0,      0,    0,    1'b0, '0},
            '{REQ_STEP,  0,      0,      0,    0,    1'b0, '0},
            '{REQ_STEP,  0,      0,      0,    0,    1'b0, '0},
            '{REQ_STEP,  0,      0,      0,    0,    1'b0, '0}
        };

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (i = 0; i < DIR_ROWS; i++)
            send_item(dir_rows[i].req, 16'(dir_rows[i].cx), 16'(dir_rows[i].cy),
                      11'(dir_rows[i].rx), 11'(dir_rows[i].ry), dir_rows[i].typed,
                      dir_rows[i].want);
        wait_idle();

        // widest window
        write_clip(-32768, 32767, -32768, 32767, 16'hFFFF);
        run_outlines(150, 40);
        wait_idle();

        // small window cutting through the outlines, random dashes
        write_clip(-$urandom_range(5, 40), $urandom_range(5, 40),
                   -$urandom_range(5, 40), $urandom_range(5, 40), 16'($urandom));
        run_outlines(150, 30);
        wait_idle();

        // empty pattern: only the start points are drawn
        write_reg(CFG_LINE_PATTERN, 16'h0000);
        run_outlines(30, 30);
        wait_idle();

        // nothing drawn: inverted window
        write_clip(32767, -32768, 32767, -32768, 16'hFFFF);
        run_outlines(20, 30);
        wait_idle();

        write_clip(-$urandom_range(0, 60), $urandom_range(0, 60),
                   -$urandom_range(0, 60), $urandom_range(0, 60),
                   16'($urandom) | 16'($urandom));
        run_outlines(90, 40);
        wait_idle();

        if (mismatch_count == 0)
            $display("PASS midpoint_ellipse_rasterizer");
        else
            $display("FAIL midpoint_ellipse_rasterizer");
        $finish;
    end

endmodule

FILE: sim.f
rtl/mer_pkg.sv
rtl/mer_ctrl.sv
rtl/mer_datapath.sv
rtl/midpoint_ellipse_rasterizer.sv
tb/sv/midpoint_ellipse_rasterizer_tb.sv
